[src/frt_pkg.sv]
// ----------------------------------------------------------------------------
// frt_pkg
// Shared constants and types for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int MAX_FRAGS    = 8;
    localparam int FRAG_PAYLOAD = 1400;
    localparam int BUFFER_BYTES = 10000;
    localparam int HEADER_BYTES = 10;

    localparam int ID_W      = 32;
    localparam int HDR_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int ACKFRAG_W = 3;
    localparam int OFFSET_W  = 14;
    localparam int LENGTH_W  = 11;

    localparam int S_FIELDS_W = ID_W + 4 * HDR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + 1 + ID_W + ACKFRAG_W + 1 + OFFSET_W + LENGTH_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED     = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_OUT_BOUNDS = 3'd2,
        ST_MALFORMED  = 3'd3,
        ST_MISMATCH   = 3'd4
    } status_t;

    typedef struct packed {
        logic [HDR_W-1:0] datagram_bytes;
        logic [HDR_W-1:0] payload_bytes;
        logic [HDR_W-1:0] fragment_total;
        logic [HDR_W-1:0] fragment_index;
        logic [ID_W-1:0]  message_id;
    } frag_hdr_t;

    typedef struct packed {
        logic                 message_done;
        logic [LENGTH_W-1:0]  store_length;
        logic [OFFSET_W-1:0]  store_offset;
        logic                 store_write;
        logic [ACKFRAG_W-1:0] ack_fragment;
        logic [ID_W-1:0]      ack_message_id;
        logic                 ack_send;
        status_t              status;
    } frag_res_t;

endpackage

[src/fragment_reassembly_tracker.sv]
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Checks fragment headers, tracks received fragments of one message in a
// bitmap and issues acknowledgement, payload store and completion results.
// ----------------------------------------------------------------------------
// Pipeline: a request is registered in an input stage, evaluated, and its
// result is registered in an output stage before the result handshake.
// Throughput: one request per cycle unless the output stalls; the tracker
// state and bitmap update in the same cycle the registered header is evaluated.
// Reset: aresetn synchronous active low; clears the tracker and both
// handshake stages.
module fragment_reassembly_tracker #(
    parameter int MAX_FRAGS    = frt_pkg::MAX_FRAGS,
    parameter int FRAG_PAYLOAD = frt_pkg::FRAG_PAYLOAD,
    parameter int BUFFER_BYTES = frt_pkg::BUFFER_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // message_id, fragment_index, fragment_total, payload_bytes, datagram_bytes
    input  logic [frt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, ack_send, ack_message_id, ack_fragment, store_write,
    // store_offset, store_length, message_done
    output logic [frt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int EXP_W = $clog2(MAX_FRAGS + 1);
    localparam int IDX_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int H_W   = frt_pkg::HDR_W;

    logic                  in_valid_reg;
    frt_pkg::frag_hdr_t    in_hdr_reg;
    logic                  out_valid_reg;
    frt_pkg::frag_res_t    out_res_reg;
    frt_pkg::frag_res_t    res_next;

    logic                  active_reg,   active_next;
    logic [frt_pkg::ID_W-1:0] tracked_reg, tracked_next;
    logic [EXP_W-1:0]      expected_reg, expected_next;
    logic [MAX_FRAGS-1:0]  map_reg,      map_next;
    logic [EXP_W-1:0]      tally_reg,    tally_next;

    logic                  advance;
    logic                  malformed;
    logic                  restart;
    logic [H_W-1:0]        exp_eff;
    logic [MAX_FRAGS-1:0]  map_eff;
    logic [EXP_W-1:0]      tally_eff;
    logic [2*H_W-1:0]      offset;
    logic [2*H_W:0]        end_byte;
    logic                  in_bounds;
    logic [MAX_FRAGS-1:0]  frag_bit;
    logic                  seen;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = frt_pkg::M_TDATA_W'(out_res_reg);

    always_comb begin
        malformed = (in_hdr_reg.fragment_total == '0)
            || (in_hdr_reg.fragment_total > H_W'(MAX_FRAGS))
            || (in_hdr_reg.fragment_index >= in_hdr_reg.fragment_total)
            || ({1'b0, in_hdr_reg.payload_bytes} > (H_W+1)'(FRAG_PAYLOAD))
            || ({1'b0, in_hdr_reg.datagram_bytes} !=
                ({1'b0, in_hdr_reg.payload_bytes} + (H_W+1)'(frt_pkg::HEADER_BYTES)));

        restart   = !active_reg || (tracked_reg != in_hdr_reg.message_id);
        exp_eff   = restart ? in_hdr_reg.fragment_total : H_W'(expected_reg);
        map_eff   = restart ? '0 : map_reg;
        tally_eff = restart ? '0 : tally_reg;

        offset    = {{H_W{1'b0}}, in_hdr_reg.fragment_index} * (2*H_W)'(FRAG_PAYLOAD);
        end_byte  = {1'b0, offset} + (2*H_W+1)'(in_hdr_reg.payload_bytes);
        in_bounds = end_byte <= (2*H_W+1)'(BUFFER_BYTES);
        frag_bit  = MAX_FRAGS'(1) << in_hdr_reg.fragment_index[IDX_W-1:0];
        seen      = (map_eff & frag_bit) != '0;

        active_next   = active_reg;
        tracked_next  = tracked_reg;
        expected_next = expected_reg;
        map_next      = map_reg;
        tally_next    = tally_reg;

        res_next                = '0;
        res_next.status         = frt_pkg::ST_MALFORMED;

        if (!malformed) begin
            active_next   = 1'b1;
            tracked_next  = in_hdr_reg.message_id;
            expected_next = EXP_W'(exp_eff);
            map_next      = map_eff;
            tally_next    = tally_eff;

            if (in_hdr_reg.fragment_total != exp_eff) begin
                res_next.status = frt_pkg::ST_MISMATCH;
            end else begin
                res_next.ack_send       = 1'b1;
                res_next.ack_message_id = in_hdr_reg.message_id;
                res_next.ack_fragment   = in_hdr_reg.fragment_index[frt_pkg::ACKFRAG_W-1:0];
                if (!in_bounds) begin
                    res_next.status = frt_pkg::ST_OUT_BOUNDS;
                end else if (seen) begin
                    res_next.status = frt_pkg::ST_DUPLICATE;
                end else begin
                    res_next.status       = frt_pkg::ST_STORED;
                    res_next.store_write  = 1'b1;
                    res_next.store_offset = offset[frt_pkg::OFFSET_W-1:0];
                    res_next.store_length =
                        in_hdr_reg.payload_bytes[frt_pkg::LENGTH_W-1:0];
                    map_next   = map_eff | frag_bit;
                    tally_next = tally_eff + EXP_W'(1);
                end
                if (H_W'(tally_next) == exp_eff) begin
                    res_next.message_done = 1'b1;
                    active_next   = 1'b0;
                    tracked_next  = '0;
                    expected_next = '0;
                    map_next      = '0;
                    tally_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            tracked_reg   <= '0;
            expected_reg  <= '0;
            map_reg       <= '0;
            tally_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                active_reg    <= active_next;
                tracked_reg   <= tracked_next;
                expected_reg  <= expected_next;
                map_reg       <= map_next;
                tally_reg     <= tally_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_hdr_reg <= s_tdata[frt_pkg::S_FIELDS_W-1:0];
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

endmodule
